// ----- rtl/core/command_line_tokenizer_core_macros.svh -----
// Assertion macros for the tokenizer RTL, included by clt_parse.
`ifndef COMMAND_LINE_TOKENIZER_CORE_MACROS_SVH
`define COMMAND_LINE_TOKENIZER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CLT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define CLT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/clt_pkg.sv -----
// Types, character codes and helpers for the command-line tokenizer.
package clt_pkg;

  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  typedef enum logic [1:0] {
    QUOTE_NONE   = 2'd0,
    QUOTE_SINGLE = 2'd1,
    QUOTE_DOUBLE = 2'd2
  } quote_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_TOO_MANY    = 2'd1,
    ST_UNTERM_QUOT = 2'd2,
    ST_TRAIL_ESC   = 2'd3
  } status_t;

  typedef struct packed {
    logic       emit;
    logic [7:0] out_char;
    logic [3:0] arg_index;
    logic       arg_begin;
    logic       arg_finish;
    logic       line_done;
    status_t    status;
    logic [4:0] arg_count;
  } result_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

endpackage

// ----- rtl/core/clt_parse.sv -----
// Tokenizer line state and the per-character update.
module clt_parse
  import clt_pkg::*;
#(
  parameter int MAX_ARGS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] char_in,
  input  logic       end_of_line,
  output result_t    res
);

`include "command_line_tokenizer_core_macros.svh"

  localparam int CNT_W = ($clog2(MAX_ARGS + 1) < 5) ? 5 : $clog2(MAX_ARGS + 1);
  localparam logic [CNT_W-1:0] ARG_LIMIT = CNT_W'(MAX_ARGS);

  logic             inside_arg, inside_arg_next;
  quote_t           open_quote, open_quote_next;
  logic             escape_pending, escape_pending_next;
  logic [CNT_W-1:0] count, count_next;
  status_t          error_code, error_code_next;

  logic             proc;
  logic             quote_hit;
  logic [CNT_W-1:0] idx_cnt;
  status_t          st;

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_arg     <= 1'b0;
      open_quote     <= QUOTE_NONE;
      escape_pending <= 1'b0;
      count          <= '0;
      error_code     <= ST_OK;
    end else if (step) begin
      inside_arg     <= inside_arg_next;
      open_quote     <= open_quote_next;
      escape_pending <= escape_pending_next;
      count          <= count_next;
      error_code     <= error_code_next;
    end
  end

  always_comb begin
    inside_arg_next     = inside_arg;
    open_quote_next     = open_quote;
    escape_pending_next = escape_pending;
    count_next          = count;
    error_code_next     = error_code;
    proc                = 1'b0;
    st                  = ST_OK;
    quote_hit           = (open_quote == QUOTE_SINGLE) ? (char_in == CH_SQUOTE)
                                                       : (char_in == CH_DQUOTE);
    res                 = '0;

    if (end_of_line) begin
      if (error_code != ST_OK) begin
        st = error_code;
      end else if (escape_pending) begin
        st = ST_TRAIL_ESC;
      end else if (open_quote != QUOTE_NONE) begin
        st = ST_UNTERM_QUOT;
      end
      res.arg_finish      = (st == ST_OK) && inside_arg;
      res.line_done       = 1'b1;
      res.status          = st;
      res.arg_count       = count[4:0];
      inside_arg_next     = 1'b0;
      open_quote_next     = QUOTE_NONE;
      escape_pending_next = 1'b0;
      count_next          = '0;
      error_code_next     = ST_OK;
    end else if (error_code == ST_OK && char_in != 8'd0) begin
      priority if (escape_pending) begin
        escape_pending_next = 1'b0;
        res.emit            = 1'b1;
        res.out_char        = char_in;
      end else if (inside_arg) begin
        proc = 1'b1;
      end else if (!is_space(char_in)) begin
        if (count >= ARG_LIMIT) begin
          error_code_next = ST_TOO_MANY;
        end else begin
          count_next      = count + 1'b1;
          inside_arg_next = 1'b1;
          res.arg_begin   = 1'b1;
          proc            = 1'b1;
        end
      end else begin
        proc = 1'b0;
      end

      if (proc) begin
        priority if (open_quote != QUOTE_NONE) begin
          priority if (quote_hit) begin
            open_quote_next = QUOTE_NONE;
          end else if (char_in == CH_BSLASH) begin
            escape_pending_next = 1'b1;
          end else begin
            res.emit     = 1'b1;
            res.out_char = char_in;
          end
        end else if (char_in == CH_SQUOTE) begin
          open_quote_next = QUOTE_SINGLE;
        end else if (char_in == CH_DQUOTE) begin
          open_quote_next = QUOTE_DOUBLE;
        end else if (char_in == CH_BSLASH) begin
          escape_pending_next = 1'b1;
        end else if (is_space(char_in)) begin
          inside_arg_next = 1'b0;
          res.arg_finish  = 1'b1;
        end else begin
          res.emit     = 1'b1;
          res.out_char = char_in;
        end
      end
    end

    idx_cnt       = end_of_line ? count : count_next;
    res.arg_index = (idx_cnt != '0) ? 4'(idx_cnt - 1'b1) : 4'd0;
  end

  `CLT_ASSERT_NEXT(a_eol_clears, step && end_of_line,
                   count == '0 && open_quote == QUOTE_NONE && !escape_pending &&
                   !inside_arg && error_code == ST_OK,
                   "line state not cleared after end of line")
  `CLT_ASSERT_NEXT(a_begin_counts, step && res.arg_begin,
                   count == $past(count) + 1'b1 && inside_arg,
                   "argument begin did not advance the count")
  `CLT_ASSERT_NEXT(a_error_sticky, step && !end_of_line && error_code != ST_OK,
                   error_code == $past(error_code),
                   "error code changed before end of line")
  `CLT_ASSERT_NOW(a_count_bound, 1'b1, count <= ARG_LIMIT,
                  "argument count beyond limit")

endmodule

// ----- rtl/core/command_line_tokenizer_core.sv -----
// A request accepted into the input register moves to the result register, and so to the master side,
// when the master side can take it. One character per cycle while the master side does not stall; the input
// and result registers decouple the two sides, and the line state updates as a request moves between them.
// Reset (rst, synchronous, active high) empties both registers and clears the line
// state: no argument open, no quote, no escape, count zero, no error.
module command_line_tokenizer_core
  import clt_pkg::*;
#(
  parameter int MAX_ARGS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
  input  logic        s_axis_tuser,   // [0] end_of_line
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] out_char, [11:8] arg_index, [13:12] status,
                                      // [18:14] arg_count, [23:19] zero
  output logic [2:0]  m_axis_tuser,   // [0] emit, [1] arg_begin, [2] arg_finish
  output logic        m_axis_tlast    // line_done
);

  logic       in_valid;
  logic [7:0] in_char;
  logic       in_eol;
  logic       out_valid;
  result_t    out_res;
  result_t    step_res;
  logic       advance;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_char <= s_axis_tdata;
      in_eol  <= s_axis_tuser;
    end
  end

  clt_parse #(
    .MAX_ARGS(MAX_ARGS)
  ) u_parse (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .char_in    (in_char),
    .end_of_line(in_eol),
    .res        (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= step_res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'd0, out_res.arg_count, out_res.status,
                          out_res.arg_index, out_res.out_char};
  assign m_axis_tuser  = {out_res.arg_finish, out_res.arg_begin, out_res.emit};
  assign m_axis_tlast  = out_res.line_done;

endmodule
